>>> hw/rtl/pgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared constants for the fixed-point PageRank engine: operation and status
// codes, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package pgr_pkg;

  // Default sizes of the node and edge stores.
  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;

  // Widths fixed by the transaction fields.
  localparam int ID_W     = 10;
  localparam int RANK_W   = 32;
  localparam int DAMP_W   = 16;
  localparam int ITER_W   = 8;
  localparam int COUNT_W  = 11;

  // Operation codes.
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DAMPING = 1'b0;
  localparam logic CFG_ITERS   = 1'b1;

  // Register reset values.
  localparam logic [DAMP_W-1:0] DAMPING_RST = 16'd55706;
  localparam logic [ITER_W-1:0] ITERS_RST   = 8'd100;

  // 1.0 in unsigned Q1.31.
  localparam logic [RANK_W-1:0] RANK_ONE = 32'h8000_0000;

endpackage

>>> hw/rtl/pgr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pgr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_div
// Restoring divider, one quotient bit per cycle. Truncating unsigned result.
// ----------------------------------------------------------------------------
module pgr_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and test against the divisor.
  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

>>> hw/rtl/pagerank_power_iteration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// Fixed-point PageRank engine with an edge store and power iteration.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; a finished result waits in an output
// register while the next transaction is taken. After reset, and on every
// clear transaction, a pass over every node entry zeroes the node store; no
// transaction is taken during the reset pass. A run first divides to get the
// initial rank and the teleport term, using the shared bit-serial divider
// whose dividend width is W = 32 + clog2(MAX_NODES+1), and writes the
// initial ranks; each iteration then sums the dangling rank, divides it,
// sends every stored edge's contribution through that divider, and
// applies damping and teleport: the node and rank memories are swept one
// entry per step.
module pagerank_power_iteration #(
  parameter int MAX_NODES = pgr_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = pgr_pkg::MAX_EDGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [pgr_pkg::DAMP_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [pgr_pkg::ID_W-1:0]     source_node,
  input  logic [pgr_pkg::ID_W-1:0]     target_node,
  input  logic [pgr_pkg::ID_W-1:0]     query_node,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pgr_pkg::RANK_W-1:0]   rank_value,
  output logic [pgr_pkg::COUNT_W-1:0]  node_count,
  output logic [1:0]                   status
);

  localparam int NB    = $clog2(MAX_NODES);
  localparam int EB    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ET_W  = $clog2(MAX_EDGES + 1);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int DVS_W = (ET_W > CNT_W) ? ET_W : CNT_W;
  localparam int DVD_W = pgr_pkg::RANK_W + CNT_W;
  localparam int RW    = pgr_pkg::RANK_W;
  localparam int NW    = ET_W + 1;

  // State codes.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_A_RS     = 5'd2;
  localparam logic [4:0] S_A_WS     = 5'd3;
  localparam logic [4:0] S_A_RT     = 5'd4;
  localparam logic [4:0] S_A_WT     = 5'd5;
  localparam logic [4:0] S_RD1      = 5'd6;
  localparam logic [4:0] S_RD2      = 5'd7;
  localparam logic [4:0] S_R_DIV0   = 5'd8;
  localparam logic [4:0] S_R_DIV1   = 5'd9;
  localparam logic [4:0] S_INIT_RD  = 5'd10;
  localparam logic [4:0] S_INIT_WR  = 5'd11;
  localparam logic [4:0] S_IA_RD    = 5'd12;
  localparam logic [4:0] S_IA_PR    = 5'd13;
  localparam logic [4:0] S_IDIV     = 5'd14;
  localparam logic [4:0] S_IE_RD    = 5'd15;
  localparam logic [4:0] S_IE_LAT   = 5'd16;
  localparam logic [4:0] S_IE_SRD   = 5'd17;
  localparam logic [4:0] S_IE_CHK   = 5'd18;
  localparam logic [4:0] S_IE_DIV   = 5'd19;
  localparam logic [4:0] S_ID_RD    = 5'd20;
  localparam logic [4:0] S_ID_SUM   = 5'd21;
  localparam logic [4:0] S_ID_MUL   = 5'd22;
  localparam logic [4:0] S_ID_WR    = 5'd23;
  localparam logic [4:0] S_DONE     = 5'd24;

  logic [4:0] state;

  // Configuration registers.
  logic [pgr_pkg::DAMP_W-1:0] damping;
  logic [pgr_pkg::ITER_W-1:0] iters;

  // Graph bookkeeping.
  logic [ET_W-1:0]  edge_total;
  logic [CNT_W-1:0] present_total;
  logic             boot;

  // Latched transaction and working registers.
  logic [NB-1:0]    src_id, tgt_id, qry_id;
  logic [NB-1:0]    addr;
  logic [EB-1:0]    eidx;
  logic [NB-1:0]    e_src, e_tgt;
  logic [RW-1:0]    init_rank, tele;
  logic [RW:0]      dterm;
  logic [DVD_W-1:0] dang;
  logic [RW-1:0]    nacc;
  logic [RW+1:0]    total;
  logic             pres;
  logic [RW+pgr_pkg::DAMP_W+1:0] prod;
  logic [pgr_pkg::ITER_W-1:0] iter;
  logic [RW-1:0]    resp_rank;
  logic [1:0]       resp_status;

  // Memory ports.
  logic            node_we;
  logic [NB-1:0]   node_waddr, node_raddr;
  logic [NW-1:0]   node_wdata, node_rdata;
  logic            edge_we;
  logic [2*NB-1:0] edge_rdata;
  logic            rank_we;
  logic [NB-1:0]   rank_waddr, rank_raddr;
  logic [RW-1:0]   rank_wdata, rank_rdata;
  logic            next_we;
  logic [NB-1:0]   next_waddr, next_raddr;
  logic [RW-1:0]   next_wdata, next_rdata;

  // Divider port.
  logic             div_go, div_busy, div_done;
  logic [DVD_W-1:0] div_a, div_q;
  logic [DVS_W-1:0] div_b;

  logic            accept, out_load, addr_last, e_last;
  logic            n_present;
  logic [ET_W-1:0] n_deg;
  logic [RW:0]     edge_sum;
  logic [RW+2:0]   new_sum;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign addr_last = (addr == NB'(MAX_NODES - 1));
  assign e_last    = (ET_W'(eidx) + ET_W'(1) == edge_total);
  assign n_present = node_rdata[ET_W];
  assign n_deg     = node_rdata[ET_W-1:0];
  assign edge_sum  = (RW+1)'(nacc) + (RW+1)'(div_q[RW-1:0]);
  assign new_sum   = (RW+3)'(tele) + (RW+3)'(prod[RW+pgr_pkg::DAMP_W+1:pgr_pkg::DAMP_W]);

  // Memory address and write selection.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = addr;
    node_wdata = '0;
    node_raddr = addr;
    edge_we    = (state == S_A_WS);
    rank_we    = 1'b0;
    rank_waddr = addr;
    rank_wdata = init_rank;
    rank_raddr = addr;
    next_we    = 1'b0;
    next_waddr = addr;
    next_wdata = '0;
    next_raddr = addr;
    unique case (state)
      S_CLR: begin
        node_we = 1'b1;
      end
      S_A_RS: begin
        node_raddr = src_id;
      end
      S_A_WS: begin
        node_we    = 1'b1;
        node_waddr = src_id;
        node_wdata = {1'b1, ET_W'(n_deg + ET_W'(1))};
      end
      S_A_RT: begin
        node_raddr = tgt_id;
      end
      S_A_WT: begin
        node_we    = !n_present;
        node_waddr = tgt_id;
        node_wdata = {1'b1, n_deg};
      end
      S_RD1: begin
        node_raddr = qry_id;
        rank_raddr = qry_id;
      end
      S_INIT_WR: begin
        rank_we = n_present;
      end
      S_IA_PR: begin
        next_we = 1'b1;
      end
      S_IE_SRD: begin
        node_raddr = e_src;
        rank_raddr = e_src;
        next_raddr = e_tgt;
      end
      S_IE_DIV: begin
        next_we    = div_done;
        next_waddr = e_tgt;
        next_wdata = edge_sum[RW] ? '1 : edge_sum[RW-1:0];
      end
      S_ID_WR: begin
        rank_we    = pres;
        rank_wdata = (|new_sum[RW+2:RW]) ? '1 : new_sum[RW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= pgr_pkg::DAMPING_RST;
      iters   <= pgr_pkg::ITERS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pgr_pkg::CFG_DAMPING: damping <= cfg_data;
        pgr_pkg::CFG_ITERS:   iters   <= pgr_pkg::ITER_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rank_value <= resp_rank;
      node_count <= pgr_pkg::COUNT_W'(present_total);
      status     <= resp_status;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      boot          <= 1'b1;
      addr          <= '0;
      edge_total    <= '0;
      present_total <= '0;
      div_go        <= 1'b0;
    end else begin
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            src_id      <= NB'(source_node);
            tgt_id      <= NB'(target_node);
            qry_id      <= NB'(query_node);
            resp_rank   <= '0;
            resp_status <= pgr_pkg::ST_OK;
            addr        <= '0;
            unique case (operation)
              pgr_pkg::OP_ADD: begin
                if (edge_total == ET_W'(MAX_EDGES) ||
                    32'(source_node) >= 32'(MAX_NODES) ||
                    32'(target_node) >= 32'(MAX_NODES)) begin
                  resp_status <= pgr_pkg::ST_DROPPED;
                  state       <= S_DONE;
                end else begin
                  state <= S_A_RS;
                end
              end
              pgr_pkg::OP_RUN: begin
                if (present_total == '0) begin
                  state <= S_DONE;
                end else begin
                  div_go <= 1'b1;
                  div_a  <= DVD_W'(pgr_pkg::RANK_ONE);
                  div_b  <= DVS_W'(present_total);
                  state  <= S_R_DIV0;
                end
              end
              pgr_pkg::OP_READ: begin
                if (32'(query_node) >= 32'(MAX_NODES)) begin
                  resp_status <= pgr_pkg::ST_ABSENT;
                  state       <= S_DONE;
                end else begin
                  state <= S_RD1;
                end
              end
              pgr_pkg::OP_CLEAR: begin
                edge_total    <= '0;
                present_total <= '0;
                state         <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        // Zero the node store one entry per cycle.
        S_CLR: begin
          addr <= addr + NB'(1);
          if (addr_last) begin
            boot  <= 1'b0;
            state <= boot ? S_IDLE : S_DONE;
          end
        end
        // Edge load: bump the source, then mark the target.
        S_A_RS: state <= S_A_WS;
        S_A_WS: begin
          if (!n_present) begin
            present_total <= present_total + CNT_W'(1);
          end
          state <= S_A_RT;
        end
        S_A_RT: state <= S_A_WT;
        S_A_WT: begin
          if (!n_present) begin
            present_total <= present_total + CNT_W'(1);
          end
          edge_total <= edge_total + ET_W'(1);
          state      <= S_DONE;
        end
        // Rank read.
        S_RD1: state <= S_RD2;
        S_RD2: begin
          if (n_present) begin
            resp_rank <= rank_rdata;
          end else begin
            resp_status <= pgr_pkg::ST_ABSENT;
          end
          state <= S_DONE;
        end
        // Run set-up: initial rank, then teleport term, then initial ranks written.
        S_R_DIV0: begin
          if (div_done) begin
            init_rank <= div_q[RW-1:0];
            div_go    <= 1'b1;
            div_a     <= DVD_W'({17'(17'h10000 - {1'b0, damping}), 15'd0});
            state     <= S_R_DIV1;
          end
        end
        S_R_DIV1: begin
          if (div_done) begin
            tele  <= div_q[RW-1:0];
            addr  <= '0;
            state <= S_INIT_RD;
          end
        end
        S_INIT_RD: state <= S_INIT_WR;
        S_INIT_WR: begin
          addr <= addr + NB'(1);
          if (!addr_last) begin
            state <= S_INIT_RD;
          end else if (iters == '0) begin
            state <= S_DONE;
          end else begin
            iter  <= '0;
            dang  <= '0;
            state <= S_IA_RD;
          end
        end
        // Iteration sweep one: clear next ranks and sum dangling rank.
        S_IA_RD: state <= S_IA_PR;
        S_IA_PR: begin
          if (n_present && n_deg == '0) begin
            dang <= dang + DVD_W'(rank_rdata);
          end
          addr <= addr + NB'(1);
          if (addr_last) begin
            div_go <= 1'b1;
            div_a  <= (n_present && n_deg == '0) ? dang + DVD_W'(rank_rdata) : dang;
            div_b  <= DVS_W'(present_total);
            state  <= S_IDIV;
          end else begin
            state <= S_IA_RD;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            dterm <= div_q[RW:0];
            eidx  <= '0;
            addr  <= '0;
            state <= (edge_total == '0) ? S_ID_RD : S_IE_RD;
          end
        end
        // Edge sweep: spread each source's rank over its out-edges.
        S_IE_RD:  state <= S_IE_LAT;
        S_IE_LAT: begin
          e_src <= edge_rdata[2*NB-1:NB];
          e_tgt <= edge_rdata[NB-1:0];
          state <= S_IE_SRD;
        end
        S_IE_SRD: state <= S_IE_CHK;
        S_IE_CHK: begin
          nacc <= next_rdata;
          if (n_deg == '0) begin
            eidx  <= eidx + EB'(1);
            state <= e_last ? S_ID_RD : S_IE_RD;
          end else begin
            div_go <= 1'b1;
            div_a  <= DVD_W'(rank_rdata);
            div_b  <= DVS_W'(n_deg);
            state  <= S_IE_DIV;
          end
        end
        S_IE_DIV: begin
          if (div_done) begin
            eidx  <= eidx + EB'(1);
            state <= e_last ? S_ID_RD : S_IE_RD;
          end
        end
        // Iteration sweep two: damping, teleport, write back.
        S_ID_RD: state <= S_ID_SUM;
        S_ID_SUM: begin
          pres  <= n_present;
          total <= (RW+2)'(next_rdata) + (RW+2)'(dterm);
          state <= S_ID_MUL;
        end
        S_ID_MUL: begin
          prod  <= (RW+pgr_pkg::DAMP_W+2)'(damping) * (RW+pgr_pkg::DAMP_W+2)'(total);
          state <= S_ID_WR;
        end
        S_ID_WR: begin
          addr <= addr + NB'(1);
          if (!addr_last) begin
            state <= S_ID_RD;
          end else if (pgr_pkg::ITER_W'(iter + 8'd1) == iters) begin
            state <= S_DONE;
          end else begin
            iter  <= iter + 8'd1;
            dang  <= '0;
            state <= S_IA_RD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Node store: present flag and out-degree.
  pgr_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Edge store: source and target per entry.
  pgr_ram #(.WIDTH(2 * NB), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (EB'(edge_total)),
    .wdata ({src_id, tgt_id}),
    .raddr (eidx),
    .rdata (edge_rdata)
  );

  // Current ranks.
  pgr_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  // Accumulated in-edge contributions.
  pgr_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  // Shared divider.
  pgr_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

`ifndef SYNTHESIS
  // The divider is never restarted while it is working.
  assert property (@(posedge clk) disable iff (rst) div_go |-> !div_busy)
    else $error("divider started while busy");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst) out_load |-> !(out_valid && out_stall))
    else $error("output register overwritten");

  // Counts stay within the store sizes.
  assert property (@(posedge clk) disable iff (rst)
    (32'(present_total) <= 32'(MAX_NODES)) && (32'(edge_total) <= 32'(MAX_EDGES)))
    else $error("node or edge count out of range");

  // An accepted transaction always makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("transaction accepted without leaving idle");
`endif

endmodule
